FILE: hw/rtl/slcg_pkg.sv
// Package for the shuffled LCG generator: constants, command codes and the
// request/response types of the modulo unit. Used by slcg_modm,
// shuffled_lcg_generator and its testbench. No dependencies.
package slcg_pkg;

  // Generator constants.
  localparam int LcgMod   = 714025;
  localparam int LcgMul   = 1366;
  localparam int LcgInc   = 150889;
  localparam int TableLen = 97;

  // Field widths.
  localparam int ValW  = 20;   // LCG values, table entries, results
  localparam int SeedW = 32;   // signed seed field

  // Products fed to the modulo unit stay below 2**PW.
  localparam int PW       = 30;
  localparam int Recip    = (2 ** PW) / LcgMod;   // floor reciprocal
  localparam int RecipW   = $clog2(Recip + 1);
  localparam int QW       = 11;                   // quotient width
  localparam int ProdW    = PW + RecipW;

  // Request kinds carried on the input tuser.
  typedef enum logic {
    CMD_DRAW   = 1'b0,   // draw the next value
    CMD_RESEED = 1'b1    // reseed with the seed field, then draw
  } slcg_cmd_e;

  // What a modulo request computes.
  typedef enum logic {
    MODE_LCG  = 1'b0,   // (LcgMul * x + LcgInc) mod LcgMod
    MODE_SLOT = 1'b1    // floor(TableDepth * x / LcgMod)
  } slcg_mode_e;

  typedef struct packed {
    logic            valid;
    slcg_mode_e      mode;
    logic [ValW-1:0] x;
  } slcg_req_t;

  typedef struct packed {
    logic            valid;
    slcg_mode_e      mode;
    logic [ValW-1:0] rem;
    logic [QW-1:0]   quo;
  } slcg_rsp_t;

endpackage

FILE: hw/rtl/shuffled_lcg_generator.sv
// Top level of the shuffled LCG generator: control sequencer, seed reduction,
// output register. Depends on slcg_pkg, slcg_ram and slcg_modm.
//
// Channel   Direction  Handshake                    Contents
// s_axis    in         s_axis_tvalid/s_axis_tready  tuser: command, tdata: seed_value
// m_axis    out        m_axis_tvalid/m_axis_tready  tdata: random_value
//
// A draw runs from acceptance to a loaded result as follows: the 4-stage
// modulo pipeline gives the slot, the table is read, and the next LCG value
// comes out of the same pipeline in the cycle after and is written back.
// A seed first goes through folding seed reduction and 98 LCG steps before
// its draw.
// Reset clears the control state and marks the generator unseeded; the table
// needs no clearing. A stalled output holds the finished result while the
// next request is already accepted; its result waits for the register.
module shuffled_lcg_generator #(
  parameter int TableDepth = slcg_pkg::TableLen
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] seed_value (signed)
  input  logic        s_axis_tuser,   // [0] command
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata    // [19:0] random_value, [23:20] zero
);

  localparam int ValW    = slcg_pkg::ValW;
  localparam int SeedW   = slcg_pkg::SeedW;
  localparam int SlotW   = $clog2(TableDepth);
  localparam int CntW    = $clog2(TableDepth + 1);
  localparam int QW      = slcg_pkg::QW;
  localparam int FoldMul = (2 ** ValW) % slcg_pkg::LcgMod;

  // Sequencer states.
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MOD   = 4'd1;
  localparam logic [3:0] S_FILL  = 4'd2;
  localparam logic [3:0] S_FWAIT = 4'd3;
  localparam logic [3:0] S_DSLOT = 4'd4;
  localparam logic [3:0] S_DLCG  = 4'd5;
  localparam logic [3:0] S_DWAIT = 4'd6;
  localparam logic [3:0] S_DWRT  = 4'd7;
  localparam logic [3:0] S_DOUT  = 4'd8;

  logic [3:0]       state_q, state_d;
  logic             seeded_q, seeded_d;
  logic [ValW-1:0]  lcg_q, lcg_d;
  logic [ValW-1:0]  last_q, last_d;
  logic [SeedW-1:0] a_q, a_d;
  logic [CntW-1:0]  idx_q, idx_d;
  logic [SlotW-1:0] slot_q, slot_d;
  logic             out_valid_q, out_valid_d;
  logic [ValW-1:0]  out_data_q, out_data_d;

  slcg_pkg::slcg_req_t req;
  slcg_pkg::slcg_rsp_t rsp;

  logic             ram_we, ram_re;
  logic [SlotW-1:0] ram_waddr, ram_raddr;
  logic [ValW-1:0]  ram_wdata, ram_rdata;

  logic in_acc, out_free, in_reseed;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign in_reseed     = (s_axis_tuser == slcg_pkg::CMD_RESEED);

  // Seed start: |150889 - seed|, since the remainder keeps the dividend's sign.
  logic [SeedW-1:0]   seed_s;
  logic signed [SeedW+1:0] seed_diff;
  logic [SeedW+1:0]   seed_abs;

  assign seed_s    = in_reseed ? s_axis_tdata : '0;
  assign seed_diff = (SeedW+2)'(slcg_pkg::LcgInc) - $signed({{2{seed_s[SeedW-1]}}, seed_s});
  assign seed_abs  = seed_diff[SeedW+1] ? (SeedW+2)'(-seed_diff) : seed_diff;

  // Seed reduction by folding: 2**20 is congruent to FoldMul, so each pass
  // replaces the bits above bit 19 by their product with FoldMul. Once they
  // are zero, one compare and subtract finishes the remainder.
  logic [SeedW-1:0] fold_sum;
  logic [ValW-1:0]  fold_low;

  assign fold_sum = SeedW'(a_q[SeedW-1:ValW]) * SeedW'(FoldMul) + SeedW'(a_q[ValW-1:0]);
  assign fold_low = (a_q[ValW-1:0] >= ValW'(slcg_pkg::LcgMod))
                  ? a_q[ValW-1:0] - ValW'(slcg_pkg::LcgMod) : a_q[ValW-1:0];

  // Slot from the modulo unit's quotient, clamped to the table.
  logic [SlotW-1:0] rsp_slot;

  assign rsp_slot = (rsp.quo >= QW'(TableDepth)) ? SlotW'(TableDepth - 1)
                                                 : rsp.quo[SlotW-1:0];

  // Sequencer.
  always_comb begin
    state_d     = state_q;
    seeded_d    = seeded_q;
    lcg_d       = lcg_q;
    last_d      = last_q;
    a_d         = a_q;
    idx_d       = idx_q;
    slot_d      = slot_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    req.valid   = 1'b0;
    req.mode    = slcg_pkg::MODE_LCG;
    req.x       = lcg_q;
    ram_we      = 1'b0;
    ram_waddr   = idx_q[SlotW-1:0];
    ram_wdata   = rsp.rem;
    ram_re      = 1'b0;
    ram_raddr   = rsp_slot;

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (in_reseed || !seeded_q) begin
            a_d     = seed_abs[SeedW-1:0];
            state_d = S_MOD;
          end else begin
            state_d = S_DSLOT;
          end
        end
      end
      S_MOD: begin
        if (a_q[SeedW-1:ValW] == '0) begin
          lcg_d   = fold_low;
          idx_d   = '0;
          state_d = S_FILL;
        end else begin
          a_d = fold_sum;
        end
      end
      S_FILL: begin
        req.valid = 1'b1;
        state_d   = S_FWAIT;
      end
      S_FWAIT: begin
        if (rsp.valid) begin
          lcg_d = rsp.rem;
          if (idx_q == CntW'(TableDepth)) begin
            last_d   = rsp.rem;
            seeded_d = 1'b1;
            state_d  = S_DSLOT;
          end else begin
            ram_we  = 1'b1;
            idx_d   = idx_q + CntW'(1);
            state_d = S_FILL;
          end
        end
      end
      S_DSLOT: begin
        req.valid = 1'b1;
        req.mode  = slcg_pkg::MODE_SLOT;
        req.x     = last_q;
        state_d   = S_DLCG;
      end
      S_DLCG: begin
        req.valid = 1'b1;
        state_d   = S_DWAIT;
      end
      S_DWAIT: begin
        if (rsp.valid && rsp.mode == slcg_pkg::MODE_SLOT) begin
          ram_re  = 1'b1;
          slot_d  = rsp_slot;
          state_d = S_DWRT;
        end
      end
      S_DWRT: begin
        // The old entry is already in the read register; refill the slot.
        if (rsp.valid && rsp.mode == slcg_pkg::MODE_LCG) begin
          ram_we    = 1'b1;
          ram_waddr = slot_q;
          lcg_d     = rsp.rem;
          state_d   = S_DOUT;
        end
      end
      S_DOUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = ram_rdata;
          last_d      = ram_rdata;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      seeded_q    <= 1'b0;
      lcg_q       <= '0;
      last_q      <= '0;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      state_q     <= state_d;
      seeded_q    <= seeded_d;
      lcg_q       <= lcg_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    a_q        <= a_d;
    slot_q     <= slot_d;
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, out_data_q};

  slcg_modm #(
    .TableDepth(TableDepth)
  ) u_modm (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req),
    .rsp_o (rsp)
  );

  slcg_ram #(
    .Width(ValW),
    .Depth(TableDepth)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // A new result only appears at the end of a draw.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == S_DOUT))
    else $error("result appeared outside the end of a draw");

  // Once seeded, the generator stays seeded.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$fell(seeded_q))
    else $error("seeded flag dropped");

  // The modulo unit never answers while the sequencer is idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid |-> state_q != S_IDLE)
    else $error("modulo response while idle");

  // A draw never starts from an unseeded state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DSLOT |-> seeded_q)
    else $error("draw without a seeded table");

endmodule

FILE: hw/rtl/slcg_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module slcg_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  parameter int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port; the data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/slcg_modm.sv
// Four-stage pipelined reduction modulo 714025 for LCG steps and slot picks.
// Depends on slcg_pkg.
module slcg_modm #(
  parameter int TableDepth = slcg_pkg::TableLen
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  slcg_pkg::slcg_req_t req_i,
  output slcg_pkg::slcg_rsp_t rsp_o
);

  localparam int PW    = slcg_pkg::PW;
  localparam int QW    = slcg_pkg::QW;
  localparam int ValW  = slcg_pkg::ValW;
  localparam int ProdW = slcg_pkg::ProdW;
  localparam int TW    = ValW + 1;

  // Stage 1: form the operand, either an LCG product or the slot product.
  logic [PW-1:0]        p1_d, p1_q;
  logic                 v1_q;
  slcg_pkg::slcg_mode_e m1_q;

  always_comb begin
    if (req_i.mode == slcg_pkg::MODE_LCG) begin
      p1_d = PW'(slcg_pkg::LcgMul) * PW'(req_i.x) + PW'(slcg_pkg::LcgInc);
    end else begin
      p1_d = PW'(TableDepth) * PW'(req_i.x);
    end
  end

  // Stage 2: quotient estimate by the floor reciprocal, low by at most one.
  logic [ProdW-1:0]     prod2;
  logic [QW-1:0]        q2_q;
  logic [PW-1:0]        p2_q;
  logic                 v2_q;
  slcg_pkg::slcg_mode_e m2_q;

  assign prod2 = ProdW'(p1_q) * ProdW'(slcg_pkg::Recip);

  // Stage 3: remainder estimate, below twice the modulus.
  logic [QW+ValW-1:0]   t3_full;
  logic [TW-1:0]        t3_q;
  logic [QW-1:0]        q3_q;
  logic                 v3_q;
  slcg_pkg::slcg_mode_e m3_q;

  assign t3_full = (QW+ValW)'(p2_q) - (QW+ValW)'(q2_q) * (QW+ValW)'(slcg_pkg::LcgMod);

  // Stage 4: one compare and subtract.
  logic [TW-1:0] t4_sub;
  logic          t4_ge;

  assign t4_ge  = t3_q >= TW'(slcg_pkg::LcgMod);
  assign t4_sub = t3_q - TW'(slcg_pkg::LcgMod);

  // Response registers.
  logic                 rsp_valid_q;
  slcg_pkg::slcg_mode_e rsp_mode_q;
  logic [ValW-1:0]      rsp_rem_q;
  logic [QW-1:0]        rsp_quo_q;

  // Valid pipeline.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      v1_q        <= req_i.valid;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      rsp_valid_q <= v3_q;
    end
  end

  // Data pipeline.
  always_ff @(posedge clk_i) begin
    p1_q       <= p1_d;
    m1_q       <= req_i.mode;
    p2_q       <= p1_q;
    q2_q       <= prod2[ProdW-1 -: QW];
    m2_q       <= m1_q;
    t3_q       <= t3_full[TW-1:0];
    q3_q       <= q2_q;
    m3_q       <= m2_q;
    rsp_mode_q <= m3_q;
    if (t4_ge) begin
      rsp_rem_q <= t4_sub[ValW-1:0];
      rsp_quo_q <= q3_q + QW'(1);
    end else begin
      rsp_rem_q <= t3_q[ValW-1:0];
      rsp_quo_q <= q3_q;
    end
  end

  // Response bundle.
  always_comb begin
    rsp_o.valid = rsp_valid_q;
    rsp_o.mode  = rsp_mode_q;
    rsp_o.rem   = rsp_rem_q;
    rsp_o.quo   = rsp_quo_q;
  end

endmodule

FILE: test/shuffled_lcg_generator_tb.sv
// Self-checking testbench for shuffled_lcg_generator: seeds and draws are
// streamed in, and every random value is checked against an in-bench model.
// Depends on slcg_pkg and the shuffled_lcg_generator RTL.
`timescale 1ns / 1ps

module shuffled_lcg_generator_tb;

  localparam int unsigned CycleLimit  = 4_000_000;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned DrainCycles = 20;
  localparam int unsigned ReseedPct   = 6;
  localparam int unsigned PhaseItems  = 170;
  localparam int unsigned PressItems  = 40;
  localparam int unsigned ShowLimit   = 20;

  typedef bit [slcg_pkg::ValW-1:0] val_t;

  // Generator model plus the queue of values still owed by the block.
  class lcg_scoreboard;
    val_t        lcg_state;
    val_t        prev_draw;
    val_t        shuffle[slcg_pkg::TableLen];
    bit          seeded;
    val_t        owed_values[$];
    int unsigned errors;

    function new();
      lcg_state = '0;
      prev_draw = '0;
      seeded    = 1'b0;
      errors    = 0;
    endfunction

    function val_t lcg_advance(val_t x);
      longint v;
      v = longint'(slcg_pkg::LcgMul) * (longint'(x) % longint'(slcg_pkg::LcgMod))
        + longint'(slcg_pkg::LcgInc);
      return val_t'(v % longint'(slcg_pkg::LcgMod));
    endfunction

    // Reduce the seed (remainder keeps the dividend's sign, then its magnitude
    // is taken), fill the table and take one more step for the first slot.
    function void load_seed(logic signed [slcg_pkg::SeedW-1:0] seed);
      longint r;
      r = (longint'(slcg_pkg::LcgInc) - longint'(seed)) % longint'(slcg_pkg::LcgMod);
      if (r < 0) r = -r;
      lcg_state = val_t'(r);
      for (int i = 0; i < slcg_pkg::TableLen; i++) begin
        lcg_state  = lcg_advance(lcg_state);
        shuffle[i] = lcg_state;
      end
      lcg_state = lcg_advance(lcg_state);
      prev_draw = lcg_state;
      seeded    = 1'b1;
    endfunction

    // Called for every accepted request; works out the value it will produce.
    function void note_request(slcg_pkg::slcg_cmd_e cmd,
                               logic [slcg_pkg::SeedW-1:0] seed);
      longint slot;
      if (cmd == slcg_pkg::CMD_RESEED) load_seed(seed);
      else if (!seeded) load_seed('0);
      slot = (longint'(slcg_pkg::TableLen) * longint'(prev_draw))
           / longint'(slcg_pkg::LcgMod);
      if (slot >= slcg_pkg::TableLen) slot = slcg_pkg::TableLen - 1;
      prev_draw     = shuffle[slot];
      lcg_state     = lcg_advance(lcg_state);
      shuffle[slot] = lcg_state;
      owed_values.push_back(prev_draw);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= ShowLimit) $display("tb: mismatch at %0t: %s", $time, msg);
    endtask

    task check_result(logic [23:0] data);
      val_t want;
      if (owed_values.size() == 0) begin
        report($sformatf("unexpected result 0x%06h", data));
      end else begin
        want = owed_values.pop_front();
        if (data !== {4'b0, want})
          report($sformatf("random_value got 0x%06h, want 0x%06h", data, {4'b0, want}));
      end
    endtask

    function int pending();
      return owed_values.size();
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;   // [31:0] seed_value (signed)
  logic        s_axis_tuser;   // [0] command
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;   // [19:0] random_value, [23:20] zero

  lcg_scoreboard board;
  int unsigned   idle_pct;
  int unsigned   stall_pct;
  int unsigned   hold_asked;
  int unsigned   hold_served;
  int unsigned   cycle_count;

  shuffled_lcg_generator uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Run limit in case the block hangs.
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count >= CycleLimit) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // Output side: random back-pressure, and a long hold-off when asked.
  initial begin
    m_axis_tready <= 1'b0;
    hold_served = 0;
    forever begin
      @(posedge clk_i);
      if (hold_served != hold_asked) begin
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_served++;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Result monitor.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) board.check_result(m_axis_tdata);
  end

  // Offer one request, with random idle cycles first, and wait for acceptance.
  // Valid stays high afterwards so back-to-back requests need no gap.
  task automatic send_request(slcg_pkg::slcg_cmd_e cmd, logic [31:0] seed);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tuser  <= 1'($urandom_range(1));
      s_axis_tdata  <= $urandom;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= seed;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    board.note_request(cmd, seed);
  endtask

  // Seeds are mostly in the legal negative range; a few are zero, small or
  // positive so the reduction sees both signs of the remainder.
  function automatic logic [31:0] pick_seed();
    case ($urandom_range(9))
      0:       return '0;
      1:       return {1'b0, 31'($urandom)};
      2:       return -32'($urandom_range(1000, 1));
      default: return {1'b1, 31'($urandom)};
    endcase
  endfunction

  // Mostly runs of draws after a reseed; draw requests carry junk seeds.
  task automatic send_random_requests(int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      if ($urandom_range(99) < ReseedPct) send_request(slcg_pkg::CMD_RESEED, pick_seed());
      else send_request(slcg_pkg::CMD_DRAW, $urandom);
    end
  endtask

  // Main sequence.
  initial begin
    board       = new();
    idle_pct    = 0;
    stall_pct   = 0;
    hold_asked  = 0;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tuser  <= 1'b0;
    s_axis_tdata  <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: a draw before any seed behaves as a zero seed.
    send_request(slcg_pkg::CMD_DRAW, 32'h7fff_ffff);
    send_request(slcg_pkg::CMD_DRAW, 32'h8000_0000);
    send_request(slcg_pkg::CMD_DRAW, 32'h0000_0000);
    // Seed extremes inside the legal range.
    send_request(slcg_pkg::CMD_RESEED, 32'h0000_0000);
    send_request(slcg_pkg::CMD_DRAW, 32'hffff_ffff);
    send_request(slcg_pkg::CMD_RESEED, 32'hffff_ffff);
    send_request(slcg_pkg::CMD_DRAW, 32'h0);
    send_request(slcg_pkg::CMD_RESEED, 32'h8000_0001);
    send_request(slcg_pkg::CMD_DRAW, 32'h0);
    send_request(slcg_pkg::CMD_RESEED, 32'h8000_0000);
    // A seed that wraps the reduction to zero from below.
    send_request(slcg_pkg::CMD_RESEED, -32'(slcg_pkg::LcgMod - slcg_pkg::LcgInc));
    send_request(slcg_pkg::CMD_DRAW, 32'h0);
    // Seeds above range: negative remainder, zero remainder, largest positive.
    send_request(slcg_pkg::CMD_RESEED, 32'(slcg_pkg::LcgInc + 1));
    send_request(slcg_pkg::CMD_DRAW, 32'h0);
    send_request(slcg_pkg::CMD_RESEED, 32'(slcg_pkg::LcgInc));
    send_request(slcg_pkg::CMD_RESEED, 32'(slcg_pkg::LcgInc + slcg_pkg::LcgMod));
    send_request(slcg_pkg::CMD_RESEED, 32'h7fff_ffff);
    for (int i = 0; i < 5; i++) send_request(slcg_pkg::CMD_DRAW, $urandom);

    // Random phases with different idle and stall mixes.
    send_random_requests(PhaseItems);
    idle_pct = 67;
    send_random_requests(PhaseItems);
    idle_pct  = 0;
    stall_pct = 67;
    send_random_requests(PhaseItems);
    idle_pct  = 13;
    stall_pct = 13;
    send_random_requests(PhaseItems);

    // Long output hold-off while requests keep coming, so the input stalls.
    idle_pct  = 0;
    stall_pct = 0;
    hold_asked++;
    send_random_requests(PressItems);
    s_axis_tvalid <= 1'b0;

    while (board.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (board.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/slcg_pkg.sv
hw/rtl/slcg_ram.sv
hw/rtl/slcg_modm.sv
hw/rtl/shuffled_lcg_generator.sv
test/shuffled_lcg_generator_tb.sv
